### src/multi_slot_heartbeat_watchdog_unit_defines.svh
// Assertion macros for the multi-slot heartbeat watchdog unit.
// Included by the top level; depends on nothing else.
`ifndef MULTI_SLOT_HEARTBEAT_WATCHDOG_UNIT_DEFINES_SVH
`define MULTI_SLOT_HEARTBEAT_WATCHDOG_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSHW_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("watchdog same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSHW_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("watchdog next-cycle check failed");

`endif

### src/mshw_pkg.sv
// Shared types and constants of the multi-slot heartbeat watchdog unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package mshw_pkg;

    // Defaults of the top-level parameters.
    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 48;

    // Fixed field widths.
    localparam int SLOT_W     = 6;
    localparam int FUNC_W     = 3;
    localparam int TMO_W      = 32;
    localparam int PERIOD_W   = 16;
    localparam int COUNT_W    = 7;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 104;

    // Safety margin added to every hardware timeout request.
    localparam int HW_MARGIN_MS = 1000;

    // Register values after reset.
    localparam logic [TMO_W-1:0]    DEFAULT_TIMEOUT_RST = 32'd3000;
    localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST    = 16'd100;
    localparam logic [TMO_W-1:0]    BOOT_GRACE_RST      = 32'd10000;
    // Start-up raise with the reset default timeout.
    localparam logic [TMO_W-1:0]    HW_TIMEOUT_RST      =
        32'(int'(DEFAULT_TIMEOUT_RST) + 2 * int'(CHECK_PERIOD_RST) + HW_MARGIN_MS);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 3'd0,
        FUNC_REGISTER = 3'd1,
        FUNC_KICK     = 3'd2,
        FUNC_SINCE    = 3'd3,
        FUNC_HEALTH   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BAD_SLOT = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_TIMEOUT = 2'd0,
        CFG_CHECK_PERIOD    = 2'd1,
        CFG_BOOT_GRACE      = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACT,
        S_SWEEP,
        S_TAIL,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              take;
        logic              act;
        logic [SLOT_W-1:0] rd_addr;
        logic              eval;
        logic [SLOT_W-1:0] eval_idx;
        logic              out_load;
    } cmd_t;

endpackage

### src/mshw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the per-slot timeouts and kick times; depends on nothing.
module mshw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/mshw_ctrl.sv
// Sequencing controller of the heartbeat watchdog: accept, act, sweep, deliver.
// Depends on mshw_pkg; drives the datapath through cmd_t.
module mshw_ctrl #(
    parameter int SLOTS = mshw_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output mshw_pkg::cmd_t cmd
);
    import mshw_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             eval_reg, eval_next;
    logic [IDX_W-1:0] eval_idx_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_load;

    // State, sweep counter and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            eval_reg      <= 1'b0;
            eval_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            eval_reg      <= eval_next;
            eval_idx_reg  <= idx_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        eval_next  = 1'b0;
        out_load   = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                idx_next   = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                // One slot read a cycle; the read data is checked once the registered read port returns it.
                eval_next = 1'b1;
                idx_next  = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Load the result only once the previous word has left.
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign cmd.take      = s_tready && s_tvalid;
    assign cmd.act       = (state_reg == S_ACT);
    assign cmd.rd_addr   = SLOT_W'(idx_reg);
    assign cmd.eval      = eval_reg;
    assign cmd.eval_idx  = SLOT_W'(eval_idx_reg);
    assign cmd.out_load  = out_load;

endmodule

### src/mshw_datapath.sv
// Datapath of the heartbeat watchdog: registers, slot memories, time and checks.
// Depends on mshw_pkg and mshw_ram; commanded by mshw_ctrl.
module mshw_datapath #(
    parameter int SLOTS     = mshw_pkg::SLOTS_DEF,
    parameter int TIME_BITS = mshw_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mshw_pkg::cmd_t                      cmd,
    input  logic                                cfg_write,
    input  logic [mshw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mshw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [mshw_pkg::FUNC_W-1:0]         in_func,
    input  logic [mshw_pkg::IN_DATA_W-1:0]      in_data,
    output logic [mshw_pkg::OUT_DATA_W-1:0]     out_data
);
    import mshw_pkg::*;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SLOTS);

    // Configuration registers.
    logic [TMO_W-1:0]    default_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TMO_W-1:0]    grace_reg;

    // Latched input word.
    logic [FUNC_W-1:0]   func_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [TMO_W-1:0]    tmo_reg;

    // Block state.
    logic [TIME_BITS-1:0] now_reg;
    logic [PERIOD_W-1:0]  pc_reg;
    logic [TMO_W-1:0]     hw_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [SLOTS-1:0]     stale_reg;

    // Per-word results.
    status_t              status_reg;
    logic [SLOT_W-1:0]    given_reg;
    logic [TMO_W-1:0]     since_reg;
    logic                 healthy_reg;
    logic                 scan_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic                 raised_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    // Action-cycle terms.
    logic [TMO_W-1:0]     tmo_eff;
    logic [TMO_W+1:0]     want_sum;
    logic [TMO_W-1:0]     want;
    logic                 raise;
    logic                 full;
    logic [SLOT_W:0]      fill_ext;
    logic                 slot_ok;
    logic [PERIOD_W-1:0]  pc_inc;
    logic                 scan_hit;
    logic [IDX_W-1:0]     fill_idx;
    logic [IDX_W-1:0]     slot_idx;

    // Memory ports.
    logic                 tmo_we;
    logic                 kick_we;
    logic [IDX_W-1:0]     kick_waddr;
    logic [IDX_W-1:0]     raddr;
    logic [TMO_W-1:0]     tmo_rdata;
    logic [TIME_BITS-1:0] kick_rdata;

    // Sweep terms.
    logic [IDX_W-1:0]     eidx;
    logic                 e_used;
    logic [TIME_BITS-1:0] diff;
    logic                 late;

    // Output terms.
    logic                 feed;
    logic [63:0]          stale_wide;
    logic [MASK_W-1:0]    mask;

    // Hardware timeout request and the checks made when a word is acted on.
    always_comb
    begin
        tmo_eff  = (tmo_reg == '0) ? default_reg : tmo_reg;
        want_sum = (TMO_W+2)'(tmo_eff) + (TMO_W+2)'({period_reg, 1'b0})
                 + (TMO_W+2)'(HW_MARGIN_MS);
        want     = (|want_sum[TMO_W+1:TMO_W]) ? '1 : want_sum[TMO_W-1:0];
        raise    = want > hw_reg;
        full     = (fill_reg == FILL_FULL);
        fill_ext = (SLOT_W+1)'(fill_reg);
        // Slots are taken in order and never freed, so used means below the fill count.
        slot_ok  = {1'b0, slot_reg} < fill_ext;
        pc_inc   = pc_reg + PERIOD_W'(1);
        scan_hit = pc_inc >= period_reg;
        fill_idx = fill_reg[IDX_W-1:0];
        slot_idx = slot_reg[IDX_W-1:0];
    end

    // Memory write and read addresses.
    always_comb
    begin
        tmo_we     = cmd.act && (func_reg == FUNC_REGISTER) && !full;
        kick_we    = tmo_we || (cmd.act && (func_reg == FUNC_KICK) && slot_ok);
        kick_waddr = (func_reg == FUNC_REGISTER) ? fill_idx : slot_idx;
        raddr      = cmd.rd_addr[IDX_W-1:0];
    end

    mshw_ram #(
        .WIDTH (TMO_W),
        .DEPTH (SLOTS)
    ) u_tmo_ram (
        .clk   (clk),
        .we    (tmo_we),
        .waddr (fill_idx),
        .wdata (tmo_eff),
        .raddr (raddr),
        .rdata (tmo_rdata)
    );

    mshw_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOTS)
    ) u_kick_ram (
        .clk   (clk),
        .we    (kick_we),
        .waddr (kick_waddr),
        .wdata (now_reg),
        .raddr (raddr),
        .rdata (kick_rdata)
    );

    // Check of one slot read back during the sweep.
    always_comb
    begin
        eidx   = cmd.eval_idx[IDX_W-1:0];
        e_used = {1'b0, cmd.eval_idx} < fill_ext;
        diff   = now_reg - kick_rdata;
        late   = (|diff[TIME_BITS-1:TMO_W]) || (diff[TMO_W-1:0] > tmo_rdata);
    end

    // Configuration, time, hardware timeout, fill count and stale flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_reg <= DEFAULT_TIMEOUT_RST;
            period_reg  <= CHECK_PERIOD_RST;
            grace_reg   <= BOOT_GRACE_RST;
            now_reg     <= '0;
            pc_reg      <= '0;
            hw_reg      <= HW_TIMEOUT_RST;
            fill_reg    <= '0;
            stale_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DEFAULT_TIMEOUT: default_reg <= cfg_data;
                    CFG_CHECK_PERIOD:    period_reg  <= cfg_data[PERIOD_W-1:0];
                    CFG_BOOT_GRACE:      grace_reg   <= cfg_data;
                    default:             ;
                endcase
            end
            if (cmd.act)
            begin
                case (func_reg)
                    FUNC_TICK:
                    begin
                        now_reg <= now_reg + TIME_BITS'(1);
                        pc_reg  <= scan_hit ? '0 : pc_inc;
                    end
                    FUNC_REGISTER:
                    begin
                        if (raise)
                        begin
                            hw_reg <= want;
                        end
                        if (!full)
                        begin
                            fill_reg            <= fill_reg + FILL_W'(1);
                            stale_reg[fill_idx] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.eval && scan_reg && e_used)
            begin
                stale_reg[eidx] <= late;
            end
        end
    end

    // Per-word results: latched input, action outcome and sweep accumulation.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            func_reg <= in_func;
            slot_reg <= in_data[SLOT_W-1:0];
            tmo_reg  <= in_data[SLOT_W+TMO_W-1:SLOT_W];
        end
        if (cmd.act)
        begin
            status_reg  <= STAT_OK;
            given_reg   <= '0;
            since_reg   <= '0;
            healthy_reg <= 1'b1;
            scan_reg    <= 1'b0;
            cnt_reg     <= '0;
            raised_reg  <= 1'b0;
            case (func_reg)
                FUNC_TICK:
                begin
                    scan_reg <= scan_hit;
                end
                FUNC_REGISTER:
                begin
                    raised_reg <= raise;
                    if (full)
                    begin
                        status_reg <= STAT_FULL;
                    end
                    else
                    begin
                        given_reg <= SLOT_W'(fill_reg);
                    end
                end
                FUNC_KICK:
                begin
                    if (!slot_ok)
                    begin
                        status_reg <= STAT_BAD_SLOT;
                    end
                end
                FUNC_SINCE:
                begin
                    if (!slot_ok)
                    begin
                        status_reg <= STAT_BAD_SLOT;
                        since_reg  <= '1;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.eval && e_used)
        begin
            if (late)
            begin
                healthy_reg <= 1'b0;
                if (scan_reg)
                begin
                    cnt_reg <= cnt_reg + COUNT_W'(1);
                end
            end
            // Capture the elapsed time of the queried slot as it passes by.
            if ((func_reg == FUNC_SINCE) && (status_reg == STAT_OK)
                && (cmd.eval_idx == slot_reg))
            begin
                since_reg <= diff[TMO_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= {5'b0, raised_reg, hw_reg, mask, cnt_reg, feed, scan_reg,
                        healthy_reg, since_reg, given_reg, status_reg};
        end
    end

    // Feed decision and stale mask of the first sixteen slots.
    always_comb
    begin
        feed       = scan_reg && ((cnt_reg == '0) || (now_reg < TIME_BITS'(grace_reg)));
        stale_wide = 64'(stale_reg);
        mask       = scan_reg ? stale_wide[MASK_W-1:0] : '0;
    end

    assign out_data = out_reg;

endmodule

### src/multi_slot_heartbeat_watchdog_unit.sv
// Multi-slot heartbeat watchdog unit, top level. Depends on mshw_pkg, mshw_ctrl,
// mshw_datapath, mshw_ram and the assertion macro header. Software registers
// heartbeat slots, kicks them and queries them; tick words advance a millisecond
// clock and every check period the unit rescans all slots, sets their stale
// flags and decides whether to feed the hardware watchdog. Every input word
// yields exactly one result word. After acceptance the unit acts on the word,
// then sweeps the timeout and kick-time memories slot by slot through their
// single read port to work out health, stale flags and the queried elapsed
// time, checks the last slot read, loads the output register and goes back
// to idle, where the next word is accepted. The result waits in that register
// while the next word is accepted; a result still held there when the following
// one is ready stalls the unit until the sink takes it. The slot memories need
// no clearing after reset; the sweep ignores what it reads for a slot that has
// not been registered.
`include "multi_slot_heartbeat_watchdog_unit_defines.svh"

module multi_slot_heartbeat_watchdog_unit #(
    parameter int SLOTS     = mshw_pkg::SLOTS_DEF,
    parameter int TIME_BITS = mshw_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input words.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, low bit up: slot [5:0], timeout [37:6], zero fill [39:38].
    input  logic [mshw_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser, low bit up: func [2:0].
    input  logic [mshw_pkg::FUNC_W-1:0]     s_tuser,
    // Result words.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, low bit up: status [1:0], slot_given [7:2], elapsed [39:8],
    // healthy [40], scan_done [41], feed [42], stale_count [49:43],
    // stale_mask [65:50], hw_timeout_ms [97:66], hw_raised [98], zero fill [103:99].
    output logic [mshw_pkg::OUT_DATA_W-1:0] m_tdata,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mshw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mshw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mshw_pkg::*;

    cmd_t cmd;

    // Registers are always writable; software writes them only while idle.
    assign cfg_ready = 1'b1;

    mshw_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mshw_datapath #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_func   (s_tuser),
        .in_data   (s_tdata),
        .out_data  (m_tdata)
    );

    // An accepted word is acted on next and blocks further words meanwhile.
    `MSHW_ASSERT_NEXT(a_take_then_act, clk, rst_n, s_tvalid && s_tready, cmd.act && !s_tready)
    // A new result never overwrites one that has not been taken.
    `MSHW_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.out_load, !m_tvalid || m_tready)
    // A loaded result is offered in the next cycle.
    `MSHW_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, m_tvalid)
    // The sweep only checks slots that exist.
    `MSHW_ASSERT_SAME(a_eval_in_range, clk, rst_n, cmd.eval, cmd.eval_idx < SLOTS)

endmodule
